[sv/assert_macros.svh]
// Assertion macros shared by the presence tracker modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define BPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Checked at every edge, reset included.
`define BPT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`else

`define BPT_ASSERT(label, clk, rst_n, prop)
`define BPT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[sv/bpt_pkg.sv]
package bpt_pkg;

    localparam int TOKEN_WIDTH_DEF = 32;
    localparam int STRENGTH_W      = 8;
    localparam int LOSS_W          = 4;
    localparam int PROX_W          = 7;
    localparam int QUEUE_DEPTH     = 2;

    // Command codes of an input request.
    localparam logic CMD_ADV      = 1'b0;
    localparam logic CMD_SCAN_END = 1'b1;

    // Event codes.
    localparam logic EV_ENTER = 1'b0;
    localparam logic EV_EXIT  = 1'b1;

    // Register indexes on the configuration port.
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_ENTER_LEVEL = 2'd0;
    localparam logic [1:0] REG_EXIT_LEVEL  = 2'd1;
    localparam logic [1:0] REG_LOSS_SCANS  = 2'd2;

    localparam logic signed [STRENGTH_W-1:0] BEST_START    = -8'sd127;
    localparam logic signed [STRENGTH_W-1:0] LOSS_STRENGTH = -8'sd100;
    localparam logic [LOSS_W-1:0]            MISSED_MAX    = 4'd15;

    typedef struct packed {
        logic signed [STRENGTH_W-1:0] enter_level;
        logic signed [STRENGTH_W-1:0] exit_level;
        logic [LOSS_W-1:0]            loss_scans;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        enter_level: -8'sd68,
        exit_level:  -8'sd74,
        loss_scans:  4'd3
    };

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // Proximity in hundredths: round((s+100)*100/45), clamped to 0..100.
    // With d = s+100 in 1..45 this is floor((40d+9)/18); the divide by 18
    // is a multiply by ceil(2^16/18) and a shift, exact for x below 1810.
    localparam int PROX_FULL_D = 46;
    localparam int PROX_MAX    = 100;

    function automatic logic [PROX_W-1:0] prox_centi(input logic signed [STRENGTH_W-1:0] s);
        logic signed [8:0] d;
        logic [10:0]       x;
        logic [22:0]       p;
        d = $signed({s[STRENGTH_W-1], s}) + 9'sd100;
        x = 11'(d[5:0]) * 11'd40 + 11'd9;
        p = 23'(x) * 23'd3641;
        if (d <= 9'sd0) begin
            return '0;
        end else if (d >= 9'(PROX_FULL_D)) begin
            return PROX_W'(PROX_MAX);
        end else begin
            return p[22:16];
        end
    endfunction

endpackage

[sv/bpt_front.sv]
module bpt_front #(
    parameter int TOKEN_WIDTH = bpt_pkg::TOKEN_WIDTH_DEF,
    parameter int DATA_W      = 1 + bpt_pkg::STRENGTH_W + TOKEN_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic                              i_service_match,
    input  logic signed [bpt_pkg::STRENGTH_W-1:0] i_strength,
    input  logic [TOKEN_WIDTH-1:0]            i_beacon_token,
    input  logic                              i_token_valid,
    input  bpt_pkg::t_qstat                   i_qstat,
    output logic                              o_push,
    output logic [DATA_W-1:0]                 o_push_data
);
    import bpt_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              accept;
    logic              useful;

    assign o_in_stall  = r_valid && i_qstat.full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = r_valid && !i_qstat.full;
    assign o_push_data = r_data;

    // Advertisements that can never be kept change nothing: drop them here.
    assign useful = (i_command == CMD_SCAN_END) || (i_service_match && i_token_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= useful;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= {i_command, i_strength, i_beacon_token};
        end
    end

endmodule

[sv/bpt_queue.sv]
`include "assert_macros.svh"

module bpt_queue #(
    parameter int DATA_W = 1 + bpt_pkg::STRENGTH_W + bpt_pkg::TOKEN_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_head,
    output bpt_pkg::t_qstat   o_qstat
);
    import bpt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CNT_W'(QUEUE_DEPTH));

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `BPT_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_qstat.full)
    `BPT_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_qstat.empty)
    `BPT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    `BPT_ASSERT(a_count_hold, i_clk, i_rst_n, (!i_push && !i_pop) |=> $stable(r_count))

endmodule

[sv/bpt_back.sv]
`include "assert_macros.svh"

module bpt_back #(
    parameter int TOKEN_WIDTH = bpt_pkg::TOKEN_WIDTH_DEF,
    parameter int DATA_W      = 1 + bpt_pkg::STRENGTH_W + TOKEN_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bpt_pkg::t_cfg                         i_cfg,
    input  bpt_pkg::t_qstat                       i_qstat,
    input  logic [DATA_W-1:0]                     i_head,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_event_kind,
    output logic [TOKEN_WIDTH-1:0]                o_event_beacon,
    output logic signed [bpt_pkg::STRENGTH_W-1:0] o_event_strength,
    output logic [bpt_pkg::PROX_W-1:0]            o_proximity_centi
);
    import bpt_pkg::*;

    logic                         head_end;
    logic signed [STRENGTH_W-1:0] head_s;
    logic [TOKEN_WIDTH-1:0]       head_tok;

    assign head_end = i_head[DATA_W-1];
    assign head_s   = $signed(i_head[TOKEN_WIDTH +: STRENGTH_W]);
    assign head_tok = i_head[TOKEN_WIDTH-1:0];

    // Presence state
    logic                   r_present,  n_present;
    logic [LOSS_W-1:0]      r_missed,   n_missed;
    logic [TOKEN_WIDTH-1:0] r_active,   n_active;
    // Running scan
    logic signed [STRENGTH_W-1:0] r_best_s, n_best_s;
    logic [TOKEN_WIDTH-1:0]       r_best_b, n_best_b;
    logic                         r_found,  n_found;
    // Result register
    logic                         r_out_valid;
    logic                         r_ev_kind;
    logic [TOKEN_WIDTH-1:0]       r_ev_beacon;
    logic signed [STRENGTH_W-1:0] r_ev_strength;
    logic [PROX_W-1:0]            r_prox;

    logic                         out_free;
    logic                         emit;
    logic                         ev_kind;
    logic [TOKEN_WIDTH-1:0]       ev_beacon;
    logic signed [STRENGTH_W-1:0] ev_strength;
    logic [LOSS_W-1:0]            missed_inc;
    logic                         pop_end;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign missed_inc = (r_missed == MISSED_MAX) ? r_missed : r_missed + 1'b1;
    assign pop_end    = o_pop && head_end;

    always_comb begin
        n_present   = r_present;
        n_missed    = r_missed;
        n_active    = r_active;
        n_best_s    = r_best_s;
        n_best_b    = r_best_b;
        n_found     = r_found;
        o_pop       = 1'b0;
        emit        = 1'b0;
        ev_kind     = EV_ENTER;
        ev_beacon   = r_best_b;
        ev_strength = r_best_s;
        if (!i_qstat.empty) begin
            if (head_end == CMD_ADV) begin
                o_pop = 1'b1;
                if (head_s > r_best_s) begin
                    n_best_s = head_s;
                    n_best_b = head_tok;
                    n_found  = 1'b1;
                end
            end else if (out_free) begin
                // Scan end: hold it until the result register can take an event.
                o_pop = 1'b1;
                if (!r_found) begin
                    if (r_present) begin
                        n_missed = missed_inc;
                        if (missed_inc >= i_cfg.loss_scans) begin
                            emit        = 1'b1;
                            ev_kind     = EV_EXIT;
                            ev_beacon   = r_active;
                            ev_strength = LOSS_STRENGTH;
                            n_present   = 1'b0;
                            n_active    = '0;
                            n_missed    = '0;
                        end
                    end
                end else begin
                    n_missed = '0;
                    if (!r_present && r_best_s >= i_cfg.enter_level) begin
                        emit      = 1'b1;
                        ev_kind   = EV_ENTER;
                        n_present = 1'b1;
                        n_active  = r_best_b;
                    end else if (r_present && r_best_s <= i_cfg.exit_level) begin
                        emit      = 1'b1;
                        ev_kind   = EV_EXIT;
                        n_present = 1'b0;
                        n_active  = '0;
                    end else if (r_present && r_active != r_best_b &&
                                 r_best_s >= i_cfg.enter_level) begin
                        emit     = 1'b1;
                        ev_kind  = EV_ENTER;
                        n_active = r_best_b;
                    end
                end
                n_best_s = BEST_START;
                n_best_b = '0;
                n_found  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= 1'b0;
            r_missed    <= '0;
            r_active    <= '0;
            r_best_s    <= BEST_START;
            r_best_b    <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_present <= n_present;
            r_missed  <= n_missed;
            r_active  <= n_active;
            r_best_s  <= n_best_s;
            r_best_b  <= n_best_b;
            r_found   <= n_found;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ev_kind     <= ev_kind;
            r_ev_beacon   <= ev_beacon;
            r_ev_strength <= ev_strength;
            r_prox        <= prox_centi(ev_strength);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_kind      = r_ev_kind;
    assign o_event_beacon    = r_ev_beacon;
    assign o_event_strength  = r_ev_strength;
    assign o_proximity_centi = r_prox;

    `BPT_ASSERT(a_enter_sets_present, i_clk, i_rst_n, (emit && ev_kind == EV_ENTER) |=> r_present)
    `BPT_ASSERT(a_exit_clears_present, i_clk, i_rst_n, (emit && ev_kind == EV_EXIT) |=> !r_present)
    `BPT_ASSERT(a_event_from_scan_end, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(pop_end))
    `BPT_ASSERT(a_loss_prox_zero, i_clk, i_rst_n,
        (r_out_valid && r_ev_strength == LOSS_STRENGTH) |-> (r_prox == '0))
    `BPT_ASSERT_ALWAYS(a_reset_no_event, i_clk, !i_rst_n |=> !r_out_valid)

endmodule

[sv/beacon_presence_tracker.sv]
// Beacon presence tracker. Requests arrive one per cycle while o_in_stall is low:
// an advertisement (command 0) joins the running scan, where the strongest
// advertisement with the expected service and a valid token is kept; a scan end
// (command 1) applies the enter/exit hysteresis rules, raises at most one event
// and starts a new scan. A front stage drops advertisements that can never be
// kept, a two-entry queue decouples it from the back end, and the back end holds
// the presence state and a result register. Sustained rate is one request per
// cycle while the output is not stalled; an advertisement leaves the queue in
// the cycle it reaches the head, a scan end waits there only while the result
// register still holds an event that has not been taken. Thresholds are written
// over the APB port at byte addresses 0 (enter level), 4 (exit level) and 8
// (loss scans); the user must write them only while idle, which the block
// itself does not enforce.
module beacon_presence_tracker #(
    parameter int TOKEN_WIDTH = bpt_pkg::TOKEN_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Advertisement and scan-end requests
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_command,
    input  logic                                  i_service_match,
    input  logic signed [bpt_pkg::STRENGTH_W-1:0] i_strength,
    input  logic [TOKEN_WIDTH-1:0]                i_beacon_token,
    input  logic                                  i_token_valid,
    // Events
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_event_kind,
    output logic [TOKEN_WIDTH-1:0]                o_event_beacon,
    output logic signed [bpt_pkg::STRENGTH_W-1:0] o_event_strength,
    output logic [bpt_pkg::PROX_W-1:0]            o_proximity_centi,
    // Configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bpt_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import bpt_pkg::*;

    localparam int DATA_W = 1 + STRENGTH_W + TOKEN_WIDTH;

    t_cfg              r_cfg;
    logic [1:0]        reg_idx;
    logic              cfg_wr;
    t_qstat            qstat;
    logic              push;
    logic [DATA_W-1:0] push_data;
    logic              pop;
    logic [DATA_W-1:0] head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ENTER_LEVEL: r_cfg.enter_level <= $signed(pwdata[STRENGTH_W-1:0]);
                REG_EXIT_LEVEL:  r_cfg.exit_level  <= $signed(pwdata[STRENGTH_W-1:0]);
                REG_LOSS_SCANS:  r_cfg.loss_scans  <= pwdata[LOSS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ENTER_LEVEL: prdata = {24'b0, r_cfg.enter_level};
            REG_EXIT_LEVEL:  prdata = {24'b0, r_cfg.exit_level};
            REG_LOSS_SCANS:  prdata = {28'b0, r_cfg.loss_scans};
            default:         prdata = '0;
        endcase
    end

    bpt_front #(
        .TOKEN_WIDTH (TOKEN_WIDTH),
        .DATA_W      (DATA_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_service_match (i_service_match),
        .i_strength      (i_strength),
        .i_beacon_token  (i_beacon_token),
        .i_token_valid   (i_token_valid),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_push_data     (push_data)
    );

    bpt_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_qstat     (qstat)
    );

    bpt_back #(
        .TOKEN_WIDTH (TOKEN_WIDTH),
        .DATA_W      (DATA_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_qstat           (qstat),
        .i_head            (head),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_event_kind      (o_event_kind),
        .o_event_beacon    (o_event_beacon),
        .o_event_strength  (o_event_strength),
        .o_proximity_centi (o_proximity_centi)
    );

endmodule

[tb/tb_beacon_presence_tracker.sv]
`timescale 1ns / 1ps

package presence_tb_pkg;
    import bpt_pkg::*;

    typedef struct {
        logic                  kind;
        logic [31:0]           beacon;
        logic signed [7:0]     strength;
        logic [PROX_W-1:0]     prox;
    } t_presence_event;

    class presence_scoreboard;
        logic signed [7:0] enter_lvl;
        logic signed [7:0] exit_lvl;
        logic [3:0]        loss_lim;

        bit                present;
        logic [3:0]        missed;
        logic [31:0]       active_tok;
        logic signed [7:0] best_str;
        logic [31:0]       best_tok;
        bit                found;

        t_presence_event   expected_events[$];
        int                fails;

        function new();
            enter_lvl  = CFG_RESET.enter_level;
            exit_lvl   = CFG_RESET.exit_level;
            loss_lim   = CFG_RESET.loss_scans;
            present    = 0;
            missed     = '0;
            active_tok = '0;
            fails      = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            best_str = BEST_START;
            best_tok = '0;
            found    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_ENTER_LEVEL: enter_lvl = value[7:0];
                REG_EXIT_LEVEL:  exit_lvl  = value[7:0];
                REG_LOSS_SCANS:  loss_lim  = value[3:0];
                default: ;
            endcase
        endfunction

        // Round to nearest hundredth; a tie cannot occur since the divisor, 45, is odd.
        static function logic [PROX_W-1:0] centi_of(logic signed [7:0] s);
            int n;
            n = (int'(s) + 100) * 100;
            if (n <= 0) return '0;
            n = (n + 22) / 45;
            if (n > 100) n = 100;
            return PROX_W'(n);
        endfunction

        function void push_event(logic k, logic [31:0] b, logic signed [7:0] s);
            t_presence_event e;
            e.kind     = k;
            e.beacon   = b;
            e.strength = s;
            e.prox     = centi_of(s);
            expected_events.push_back(e);
        endfunction

        function void note_request(logic cmd, logic svc, logic signed [7:0] s,
                                   logic [31:0] tok, logic tv);
            if (cmd == CMD_ADV) begin
                if (svc && tv && s > best_str) begin
                    best_str = s;
                    best_tok = tok;
                    found    = 1;
                end
                return;
            end
            if (!found) begin
                if (present) begin
                    if (missed != MISSED_MAX) missed = missed + 1'b1;
                    if (missed >= loss_lim) begin
                        push_event(EV_EXIT, active_tok, LOSS_STRENGTH);
                        present    = 0;
                        active_tok = '0;
                        missed     = '0;
                    end
                end
            end else begin
                missed = '0;
                if (!present && best_str >= enter_lvl) begin
                    present    = 1;
                    active_tok = best_tok;
                    push_event(EV_ENTER, best_tok, best_str);
                end else if (present && best_str <= exit_lvl) begin
                    present    = 0;
                    active_tok = '0;
                    push_event(EV_EXIT, best_tok, best_str);
                end else if (present && active_tok != best_tok && best_str >= enter_lvl) begin
                    active_tok = best_tok;
                    push_event(EV_ENTER, best_tok, best_str);
                end
            end
            clear_scan();
        endfunction

        function void check_event(logic k, logic [31:0] b, logic signed [7:0] s,
                                  logic [PROX_W-1:0] p);
            t_presence_event e;
            if (expected_events.size() == 0) begin
                $error("unexpected event: kind %0d beacon %h strength %0d proximity %0d",
                       k, b, s, p);
                fails++;
                return;
            end
            e = expected_events.pop_front();
            if (k !== e.kind) begin
                $error("event_kind: expected %0d, got %0d", e.kind, k);
                fails++;
            end
            if (b !== e.beacon) begin
                $error("event_beacon: expected %h, got %h", e.beacon, b);
                fails++;
            end
            if (s !== e.strength) begin
                $error("event_strength: expected %0d, got %0d", e.strength, s);
                fails++;
            end
            if (p !== e.prox) begin
                $error("proximity_centi: expected %0d, got %0d", e.prox, p);
                fails++;
            end
        endfunction
    endclass
endpackage

module tb_beacon_presence_tracker;
    import bpt_pkg::*;
    import presence_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_command;
    logic                         i_service_match;
    logic signed [STRENGTH_W-1:0] i_strength;
    logic [31:0]                  i_beacon_token;
    logic                         i_token_valid;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic                         o_event_kind;
    logic [31:0]                  o_event_beacon;
    logic signed [STRENGTH_W-1:0] o_event_strength;
    logic [PROX_W-1:0]            o_proximity_centi;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_W-1:0]        paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    presence_scoreboard sb = new();

    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    logic [31:0] token_pool[3];

    beacon_presence_tracker DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_service_match   (i_service_match),
        .i_strength        (i_strength),
        .i_beacon_token    (i_beacon_token),
        .i_token_valid     (i_token_valid),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_event_kind      (o_event_kind),
        .o_event_beacon    (o_event_beacon),
        .o_event_strength  (o_event_strength),
        .o_proximity_centi (o_proximity_centi),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_event(o_event_kind, o_event_beacon, o_event_strength, o_proximity_centi);
    end

    // Offer one request; valid stays high on return so back-to-back requests
    // need no extra assignment.
    task automatic send_request(logic cmd, logic svc, logic signed [7:0] s,
                                logic [31:0] tok, logic tv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_command       = cmd;
        i_service_match = svc;
        i_strength      = s;
        i_beacon_token  = tok;
        i_token_valid   = tv;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(cmd, svc, s, tok, tv);
        @(negedge i_clk);
    endtask

    task automatic send_adv(logic signed [7:0] s, logic [31:0] tok);
        send_request(CMD_ADV, 1'b1, s, tok, 1'b1);
    endtask

    // Fields other than the command carry noise on a scan end.
    task automatic send_scan_end();
        send_request(CMD_SCAN_END, 1'($urandom), 8'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.expected_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [7:0] pick_strength();
        int r;
        r = $urandom_range(9);
        if (r < 4) return 8'(int'(sb.enter_lvl) + int'($urandom_range(6)) - 3);
        if (r < 8) return 8'(int'(sb.exit_lvl) + int'($urandom_range(6)) - 3);
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_token();
        int r;
        r = $urandom_range(4);
        if (r < 3) return token_pool[r];
        return $urandom;
    endfunction

    task automatic run_random(int n_items);
        int sent;
        int n_ads;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_request(1'($urandom), 1'($urandom), 8'($urandom), $urandom,
                             1'($urandom));
                sent++;
            end else if (r < 13) begin
                // run of empty scans long enough to reach the loss limit
                for (int k = 0; k <= sb.loss_lim; k++) begin
                    send_scan_end();
                    sent++;
                end
            end else begin
                n_ads = $urandom_range(4);
                for (int k = 0; k < n_ads; k++) begin
                    send_request(CMD_ADV, $urandom_range(7) != 0, pick_strength(),
                                 pick_token(), $urandom_range(7) != 0);
                    sent++;
                end
                send_scan_end();
                sent++;
            end
        end
    endtask

    task automatic run_phase(logic signed [7:0] enter_lvl, logic signed [7:0] exit_lvl,
                             logic [3:0] loss, int idle_pct, int stall_p, bit hold,
                             int n_items);
        drain();
        apb_write(REG_ENTER_LEVEL, {{24{enter_lvl[7]}}, enter_lvl});
        apb_write(REG_EXIT_LEVEL, {{24{exit_lvl[7]}}, exit_lvl});
        apb_write(REG_LOSS_SCANS, {28'd0, loss});
        foreach (token_pool[k]) token_pool[k] = $urandom;
        send_idle_pct = idle_pct;
        stall_pct     = stall_p;
        if (hold) hold_requests++;
        run_random(n_items);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_ADV;
        i_service_match = 1'b0;
        i_strength      = '0;
        i_beacon_token  = '0;
        i_token_valid   = 1'b0;
        i_out_stall     = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        foreach (token_pool[k]) token_pool[k] = $urandom;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset thresholds.
        send_request(CMD_ADV, 1'b0, 8'sd20, 32'h0000_00AA, 1'b1);  // wrong service
        send_request(CMD_ADV, 1'b1, 8'sd20, 32'h0000_00BB, 1'b0);  // empty token
        send_adv(-8'sd128, 32'h0000_00CC);                           // never kept
        send_scan_end();                                             // absent, nothing found
        send_adv(-8'sd68, 32'hFFFF_FFFF);                            // enter at the level
        send_adv(-8'sd68, 32'h0000_0000);                            // tie, not kept
        send_scan_end();
        send_adv(8'sd20, 32'h1234_5678);                             // switch beacon
        send_scan_end();
        send_adv(-8'sd70, 32'h1234_5678);                            // between the levels
        send_scan_end();
        send_scan_end();
        send_scan_end();
        send_adv(-8'sd127, 32'h5555_5555);                           // equals start, not kept
        send_scan_end();                                             // loss exit
        send_adv(8'sd127, 32'h0000_0000);
        send_scan_end();                                             // enter, clamped score
        send_adv(-8'sd74, 32'h0000_0000);
        send_scan_end();                                             // exit at the level
        send_adv(-8'sd100, 32'h8000_0000);
        send_scan_end();                                             // too weak to enter

        run_phase(-8'sd68, -8'sd74, 4'd3, 0, 0, 1'b0, 80);
        run_phase(8'sd20, -8'sd127, 4'd15, 75, 0, 1'b0, 80);
        run_phase(-8'sd127, 8'sd20, 4'd1, 0, 75, 1'b0, 80);
        run_phase(-8'sd90, -8'sd60, 4'd0, 19, 19, 1'b0, 80);
        run_phase(-8'sd68, -8'sd74, 4'd3, 0, 0, 1'b1, 80);
        run_phase(-8'sd80, -8'sd85, 4'd2, 19, 19, 1'b0, 40);

        drain();
        if (sb.fails == 0 && sb.expected_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
